FILE: rtl/slst_pkg.sv
// Package for the sorted list store: operation and status codes,
// the value type and the control and flag structs shared by the cell row.
// No dependencies.
`timescale 1ns / 1ps

package slst_pkg;

  localparam int VAL_W = 32;
  localparam int CNT_OUT_W = 5;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic ins;  // insert the key at the lower-bound position
    logic del;  // remove the lower-bound entry, which equals the key
    logic clr;  // invalidate every entry
    val_t key;
  } cell_ctl_t;

  // Compare results that one cell reports about itself.
  typedef struct packed {
    logic lt;   // valid and below the key
    logic bnd;  // first valid entry not below the key
    logic hit;  // boundary entry equal to the key
  } cell_flags_t;

endpackage

FILE: rtl/slst_req_if.sv
// Request channel of the sorted list store: valid/ready plus one item.
// Depends on slst_pkg.
`timescale 1ns / 1ps

interface slst_req_if;
  import slst_pkg::*;

  logic valid;
  logic ready;
  op_e  operation;
  val_t value;

  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);
endinterface

FILE: rtl/slst_rsp_if.sv
// Response channel of the sorted list store: valid/ready plus one result item.
// Depends on slst_pkg.
`timescale 1ns / 1ps

interface slst_rsp_if;
  import slst_pkg::*;

  logic           valid;
  logic           ready;
  status_e        status;
  val_t           found_value;
  logic [CNT_OUT_W-1:0] entry_count;

  modport source (output valid, output status, output found_value,
                  output entry_count, input ready);
  modport sink (input valid, input status, input found_value,
                input entry_count, output ready);
endinterface

FILE: rtl/slst_cell.sv
// One cell of the sorted row: holds a single entry and its valid bit, and
// shifts toward either neighbor on insert or delete. Depends on slst_pkg.
`timescale 1ns / 1ps

module slst_cell import slst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cell_ctl_t   ctl,
  input  logic        left_lt,
  input  logic        left_vld,
  input  val_t        left_val,
  input  logic        right_vld,
  input  val_t        right_val,
  output val_t        val,
  output logic        vld,
  output cell_flags_t flags
);

  val_t val_next;
  logic vld_next;

  // Local compare against the broadcast key.
  always_comb begin
    flags.lt  = vld && (val < ctl.key);
    flags.bnd = vld && !flags.lt && left_lt;
    flags.hit = flags.bnd && (val == ctl.key);
  end

  // Clear drops the entry; else entries below the key stay, the rest take the key or a neighbor's entry.
  always_comb begin
    val_next = val;
    vld_next = vld;
    if (ctl.clr) begin
      vld_next = 1'b0;
    end else if (ctl.ins && !flags.lt) begin
      if (left_lt) begin
        val_next = ctl.key;
        vld_next = 1'b1;
      end else begin
        val_next = left_val;
        vld_next = left_vld;
      end
    end else if (ctl.del && !flags.lt) begin
      val_next = right_val;
      vld_next = right_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

FILE: rtl/sorted_list_store.sv
// Sorted list store: up to CAPACITY signed 32-bit entries kept in ascending
// order, duplicates allowed. Channels: req carries an operation (insert,
// delete, find lower bound, clear) and a value; rsp returns one result per
// item with a status, the found value (zero unless a find succeeds) and the
// entry count after the operation, truncated to five bits.
// Each item is accepted at a clock edge and its result is valid from the
// next cycle, so one item per cycle is sustained while the receiver takes
// its results. The rate is set by the row of compare-and-shift cells, which
// all compare the key and move their entries toward a neighbor in the same cycle.
// The result sits in an output register; req stays ready while that register
// is empty or being read out, so a stalled receiver holds its result and
// stops new items only until it takes it.
// Synchronous reset (rst) empties the store and the output register; the
// entry contents are not cleared, only their valid bits.
// Inserting into a full store drops the value and reports full status.
// Depends on slst_pkg, slst_req_if, slst_rsp_if and slst_cell.
`timescale 1ns / 1ps

module sorted_list_store import slst_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic   clk,
  input  logic   rst,
  slst_req_if.sink   req,
  slst_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  val_t        cell_val [CAPACITY];
  logic [CAPACITY-1:0] vld_vec;
  cell_flags_t cell_flg [CAPACITY];
  cell_ctl_t   ctl;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             full;
  logic             accept;
  logic             del_hit;
  logic             any_bnd;
  val_t             bnd_val;

  logic             rsp_valid;
  status_e          rsp_status;
  val_t             rsp_found;
  logic [CNT_OUT_W-1:0] rsp_count;
  status_e          status_next;
  val_t             found_next;
  logic [CNT_W+CNT_OUT_W-1:0] count_ext;

  assign accept    = req.valid && req.ready;
  assign req.ready = !rsp_valid || rsp.ready;
  assign full      = (count == CNT_W'(CAPACITY));

  // Reduce the boundary flags of the row: delete match and find result.
  always_comb begin
    del_hit = 1'b0;
    any_bnd = 1'b0;
    bnd_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      del_hit = del_hit | cell_flg[i].hit;
      any_bnd = any_bnd | cell_flg[i].bnd;
      bnd_val = bnd_val | (cell_flg[i].bnd ? cell_val[i] : '0);
    end
  end

  // Command broadcast to the row.
  always_comb begin
    ctl.key = req.value;
    ctl.ins = accept && (req.operation == OP_INSERT) && !full;
    ctl.del = accept && (req.operation == OP_DELETE) && del_hit;
    ctl.clr = accept && (req.operation == OP_CLEAR);
  end

  // Row of cells; the ends see an always-lower left side and an empty right.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic left_lt;
    logic left_vld;
    val_t left_val;
    logic right_vld;
    val_t right_val;

    if (i == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_vld = 1'b0;
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_lt  = cell_flg[i-1].lt;
      assign left_vld = vld_vec[i-1];
      assign left_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_vld = 1'b0;
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_vld = vld_vec[i+1];
      assign right_val = cell_val[i+1];
    end

    slst_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .left_lt   (left_lt),
      .left_vld  (left_vld),
      .left_val  (left_val),
      .right_vld (right_vld),
      .right_val (right_val),
      .val       (cell_val[i]),
      .vld       (vld_vec[i]),
      .flags     (cell_flg[i])
    );
  end

  // Entry count and result of the current item.
  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    found_next  = '0;
    case (req.operation)
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (del_hit) begin
          count_next = count - CNT_W'(1);
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      OP_FIND: begin
        if (any_bnd) begin
          found_next = bnd_val;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
    count_ext = {{CNT_OUT_W{1'b0}}, count_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_status <= status_next;
      rsp_found  <= found_next;
      rsp_count  <= count_ext[CNT_OUT_W-1:0];
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.found_value = rsp_found;
  assign rsp.entry_count = rsp_count;

`ifndef SYNTHESIS
  // Valid entries and the count always agree.
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(vld_vec) == count)
    else $error("valid bits disagree with entry count");

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // A clear empties the store in the next cycle.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && req.operation == OP_CLEAR |=> rsp.valid && count == '0 && vld_vec == '0)
    else $error("clear did not empty the store");

  // A dropped insert only happens on a full store.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    accept && req.operation == OP_INSERT && !full |=> rsp.status == ST_OK)
    else $error("insert reported full on a store with room");
`endif

endmodule
